@@ rtl/cms_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cms_pkg
// Shared types and constants of the charlieplexed matrix scanner.
// ----------------------------------------------------------------------------
package cms_pkg;

    localparam int LINES           = 23;
    localparam int SIDE            = LINES - 1;
    localparam int BYTES_PER_GROUP = 11;
    localparam int BANK_BYTES      = ((SIDE + 7) / 8) * SIDE;
    localparam int RAM_DEPTH       = 2 * BANK_BYTES;
    localparam int ADDR_W          = $clog2(RAM_DEPTH);
    localparam int LINE_W          = $clog2(LINES);
    localparam int IDX_W           = 7;
    localparam int BYTE_W          = 8;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_PRESENT = 2'd2
    } t_cmd;

    // scan step information handed from the controller to the output stage
    typedef struct packed {
        logic [LINE_W-1:0] high_line;
        logic [LINE_W-1:0] low_line;
        logic [2:0]        bit_sel;
        logic              shown_valid;
        logic              frame_wrap;
    } t_scan_info;

endpackage
`default_nettype wire

@@ rtl/cms_bitmap_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cms_bitmap_ram
// Two-bank bitmap store, one write and one registered read per cycle.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module cms_bitmap_ram (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_wr_en,
    input  wire logic [cms_pkg::ADDR_W-1:0]  i_wr_addr,
    input  wire logic [cms_pkg::BYTE_W-1:0]  i_wr_data,
    input  wire logic                        i_rd_en,
    input  wire logic [cms_pkg::ADDR_W-1:0]  i_rd_addr,
    output logic      [cms_pkg::BYTE_W-1:0]  o_rd_data
);

    logic [cms_pkg::BYTE_W-1:0] r_mem [cms_pkg::RAM_DEPTH];
    logic [cms_pkg::RAM_DEPTH-1:0] r_vld;
    logic [cms_pkg::BYTE_W-1:0] r_rd_data;
    logic                       r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule
`default_nettype wire

@@ rtl/cms_scan_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cms_scan_ctrl
// Scan position counter, bank arming and pixel address generation.
// ----------------------------------------------------------------------------
module cms_scan_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_tick,
    input  wire logic                        i_present,
    input  wire logic                        i_bank,
    output logic      [cms_pkg::ADDR_W-1:0]  o_rd_addr,
    output cms_pkg::t_scan_info              o_info
);

    localparam int LW = cms_pkg::LINE_W;

    logic [LW-1:0] r_x, r_y;
    logic          r_shown_bank, r_shown_valid, r_pend_bank, r_pend_valid;

    logic [LW-1:0] n_x, n_y, y_swap, low;
    logic          wrap, n_shown_bank, n_shown_valid;
    logic [cms_pkg::ADDR_W-1:0] byte_addr;

    always_comb begin
        if (r_y == LW'(cms_pkg::SIDE - 1)) begin
            n_y = '0;
            n_x = (r_x == LW'(cms_pkg::SIDE - 1)) ? '0 : r_x + 1'b1;
        end else begin
            n_y = r_y + 1'b1;
            n_x = r_x;
        end
        wrap = (n_x == '0) && (n_y == '0);
        n_shown_bank  = (wrap && r_pend_valid) ? r_pend_bank : r_shown_bank;
        n_shown_valid = (wrap && r_pend_valid) ? 1'b1 : r_shown_valid;

        byte_addr = cms_pkg::ADDR_W'(n_y[LW-1:1])
                  + cms_pkg::ADDR_W'(n_x[LW-1:2]) * cms_pkg::ADDR_W'(cms_pkg::BYTES_PER_GROUP);
        o_rd_addr = n_shown_bank ? byte_addr + cms_pkg::ADDR_W'(cms_pkg::BANK_BYTES)
                                 : byte_addr;

        // swap the first two rows of column zero
        if ((n_x == '0) && (n_y <= LW'(1))) begin
            y_swap = {{(LW-1){1'b0}}, ~n_y[0]};
        end else begin
            y_swap = n_y;
        end
        low = (y_swap >= n_x) ? y_swap + 1'b1 : y_swap;

        o_info.high_line   = n_x;
        o_info.low_line    = low;
        o_info.bit_sel     = {n_x[1:0], n_y[0]};
        o_info.shown_valid = n_shown_valid;
        o_info.frame_wrap  = wrap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x           <= '0;
            r_y           <= '0;
            r_shown_bank  <= 1'b0;
            r_shown_valid <= 1'b0;
            r_pend_bank   <= 1'b0;
            r_pend_valid  <= 1'b0;
        end else if (i_tick) begin
            r_x           <= n_x;
            r_y           <= n_y;
            r_shown_bank  <= n_shown_bank;
            r_shown_valid <= n_shown_valid;
            if (wrap) begin
                r_pend_valid <= 1'b0;
            end
        end else if (i_present) begin
            r_pend_bank  <= i_bank;
            r_pend_valid <= 1'b1;
        end
    end

endmodule
`default_nettype wire

@@ rtl/charlieplex_matrix_scanner_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// charlieplex_matrix_scanner_core
// Scanner for a 23-line charlieplexed matrix with a double-buffered bitmap.
// ----------------------------------------------------------------------------
// Beats may follow back to back while the input is not stalled. A scan
// tick gives one result beat, registered first by the bitmap RAM read and
// then in the output register. Writes and present commands give no result.
// The bitmap RAM has one write and one read port; per-entry valid bits stand
// in for the clear at reset, so no sweep is needed. The input stalls only
// when the read stage and the output are both full and m_axis_tready is low.
module charlieplex_matrix_scanner_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // bank [0], byte_index [7:1], byte_value [15:8]
    input  wire logic [15:0] s_axis_tdata,
    // cmd [1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // high_line [4:0], low_line [9:5], lit [10], frame_wrap [11], zero [15:12]
    output logic [15:0]      m_axis_tdata
);

    localparam int LW = cms_pkg::LINE_W;

    logic accept, tick_acc, present_acc, wr_acc, s1_adv;
    logic [cms_pkg::ADDR_W-1:0] rd_addr, wr_addr;
    logic [cms_pkg::BYTE_W-1:0] rd_data;
    logic [cms_pkg::IDX_W-1:0]  wr_idx;
    logic                       in_bank;
    cms_pkg::t_scan_info        info;

    cms_pkg::t_scan_info r_s1_info;
    logic                r_s1_valid;
    logic                r_out_valid;
    logic [15:0]         r_out_data;
    logic                lit;

    assign in_bank = s_axis_tdata[0];
    assign wr_idx  = s_axis_tdata[7:1];
    assign accept  = s_axis_tvalid && s_axis_tready;

    always_comb begin
        tick_acc    = 1'b0;
        present_acc = 1'b0;
        wr_acc      = 1'b0;
        case (cms_pkg::t_cmd'(s_axis_tuser))
            cms_pkg::CMD_TICK:    tick_acc    = accept;
            cms_pkg::CMD_PRESENT: present_acc = accept;
            // drop writes beyond the bank
            cms_pkg::CMD_WRITE:   wr_acc = accept &&
                                           (wr_idx < cms_pkg::IDX_W'(cms_pkg::BANK_BYTES));
            default: ;
        endcase
        wr_addr = cms_pkg::ADDR_W'(wr_idx)
                + (in_bank ? cms_pkg::ADDR_W'(cms_pkg::BANK_BYTES) : '0);
    end

    cms_scan_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick    (tick_acc),
        .i_present (present_acc),
        .i_bank    (in_bank),
        .o_rd_addr (rd_addr),
        .o_info    (info)
    );

    cms_bitmap_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_acc),
        .i_wr_addr (wr_addr),
        .i_wr_data (s_axis_tdata[15:8]),
        .i_rd_en   (tick_acc),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign s1_adv        = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign lit           = r_s1_info.shown_valid && rd_data[r_s1_info.bit_sel];

    always_ff @(posedge i_clk) begin
        if (tick_acc) begin
            r_s1_info <= info;
        end
        if (s1_adv && r_s1_valid) begin
            r_out_data <= {4'b0000, r_s1_info.frame_wrap, lit,
                           lit ? r_s1_info.low_line  : LW'(0),
                           lit ? r_s1_info.high_line : LW'(0)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_s1_valid <= tick_acc;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire
